// File: design/ffa_pkg.sv
// Shared types and constants for the first-fit free-list allocator.
// Used by the request/result interfaces, the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

    // Fixed field widths of the request and result transactions.
    localparam int BYTES_W   = 16;
    localparam int PAYLOAD_W = 12;
    localparam int STATUS_W  = 2;
    localparam int GROW_W    = 12;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_MIN_GROW = 1'b0;
    localparam logic [GROW_W-1:0] MIN_GROW_RESET = 12'd1024;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREE  = 2'd2;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_NEED,
        OP_F_START,
        OP_A_FOLLOW,
        OP_A_EXACT,
        OP_A_SPLIT1,
        OP_A_SPLIT2,
        OP_A_ADV,
        OP_A_OOM,
        OP_A_REGROW,
        OP_G_GROW,
        OP_R_START,
        OP_R_ADV,
        OP_R_FOUND,
        OP_R_BLINK,
        OP_R_BREAD,
        OP_R_BMERGE,
        OP_R_PREAD,
        OP_R_PLINK,
        OP_R_PSTORE,
        OP_R_PMERGE,
        OP_OUT
    } t_dp_op;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic cmd_free;
        logic free_ok;
        logic a_fit;
        logic a_exact;
        logic a_at_rover;
        logic a_steps_end;
        logic g_fail;
        logic r_found;
        logic r_steps_end;
        logic r_merge_b;
        logic r_merge_p;
        logic out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// File: design/ffa_req_if.sv
// Request channel of the allocator: valid/ready handshake and request fields.
// Depends on ffa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ffa_req_if import ffa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [BYTES_W-1:0]   request_bytes;
    logic [PAYLOAD_W-1:0] free_unit;

    modport source (output valid, output command, output request_bytes, output free_unit,
                    input ready);
    modport sink   (input valid, input command, input request_bytes, input free_unit,
                    output ready);
endinterface

`default_nettype wire

// File: design/ffa_rsp_if.sv
// Result channel of the allocator: valid/ready handshake and result fields.
// Depends on ffa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ffa_rsp_if import ffa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PAYLOAD_W-1:0] payload_unit;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, output payload_unit, output status, input ready);
    modport sink   (input valid, input payload_unit, input status, output ready);
endinterface

`default_nettype wire

// File: design/ffa_ctrl.sv
// Controller state machine of the allocator: sequences allocate, grow and free steps.
// Depends on ffa_pkg; drives ffa_dp through t_dp_op and reads t_dp_status.
`timescale 1ns / 1ps
`default_nettype none

module ffa_ctrl import ffa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_st,
    output t_dp_op     o_op
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_DECODE   = 16'b0000_0000_0000_0010,
        S_NEED     = 16'b0000_0000_0000_0100,
        S_A_FOLLOW = 16'b0000_0000_0000_1000,
        S_A_CHK    = 16'b0000_0000_0001_0000,
        S_A_SPLIT  = 16'b0000_0000_0010_0000,
        S_GROW     = 16'b0000_0000_0100_0000,
        S_R_START  = 16'b0000_0000_1000_0000,
        S_R_WALK   = 16'b0000_0001_0000_0000,
        S_R_B      = 16'b0000_0010_0000_0000,
        S_R_MN     = 16'b0000_0100_0000_0000,
        S_R_P      = 16'b0000_1000_0000_0000,
        S_R_PD     = 16'b0001_0000_0000_0000,
        S_R_MP     = 16'b0010_0000_0000_0000,
        S_A_REGROW = 16'b0100_0000_0000_0000,
        S_FIN      = 16'b1000_0000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ctx_grow;
    logic   n_ctx_grow;
    t_state rel_end;

    // Where a finished insertion returns to: the allocate walk after a grow,
    // or straight to the result for a free.
    assign rel_end    = r_ctx_grow ? S_A_REGROW : S_FIN;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_ctx_grow = r_ctx_grow;
        o_op       = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_ctx_grow = 1'b0;
                if (i_st.cmd_free) begin
                    o_op    = OP_F_START;
                    n_state = i_st.free_ok ? S_R_START : S_FIN;
                end else begin
                    o_op    = OP_MUL;
                    n_state = S_NEED;
                end
            end
            S_NEED: begin
                o_op    = OP_NEED;
                n_state = S_A_FOLLOW;
            end
            S_A_FOLLOW: begin
                o_op    = OP_A_FOLLOW;
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (i_st.a_fit) begin
                    if (i_st.a_exact) begin
                        o_op    = OP_A_EXACT;
                        n_state = S_FIN;
                    end else begin
                        o_op    = OP_A_SPLIT1;
                        n_state = S_A_SPLIT;
                    end
                end else if (i_st.a_at_rover) begin
                    n_state = S_GROW;
                end else if (i_st.a_steps_end) begin
                    o_op    = OP_A_OOM;
                    n_state = S_FIN;
                end else begin
                    o_op = OP_A_ADV;
                end
            end
            S_A_SPLIT: begin
                o_op    = OP_A_SPLIT2;
                n_state = S_FIN;
            end
            S_GROW: begin
                if (i_st.g_fail) begin
                    o_op    = OP_A_OOM;
                    n_state = S_FIN;
                end else begin
                    o_op       = OP_G_GROW;
                    n_ctx_grow = 1'b1;
                    n_state    = S_R_START;
                end
            end
            S_R_START: begin
                o_op    = OP_R_START;
                n_state = S_R_WALK;
            end
            S_R_WALK: begin
                if (i_st.r_found) begin
                    o_op    = OP_R_FOUND;
                    n_state = S_R_B;
                end else if (i_st.r_steps_end) begin
                    n_state = rel_end;
                end else begin
                    o_op = OP_R_ADV;
                end
            end
            S_R_B: begin
                if (i_st.r_merge_b) begin
                    o_op    = OP_R_BREAD;
                    n_state = S_R_MN;
                end else begin
                    o_op    = OP_R_BLINK;
                    n_state = S_R_P;
                end
            end
            S_R_MN: begin
                o_op    = OP_R_BMERGE;
                n_state = S_R_P;
            end
            S_R_P: begin
                o_op    = OP_R_PREAD;
                n_state = S_R_PD;
            end
            S_R_PD: begin
                if (i_st.r_merge_p) begin
                    o_op    = OP_R_PSTORE;
                    n_state = S_R_MP;
                end else begin
                    o_op    = OP_R_PLINK;
                    n_state = rel_end;
                end
            end
            S_R_MP: begin
                o_op    = OP_R_PMERGE;
                n_state = rel_end;
            end
            S_A_REGROW: begin
                if (i_st.a_steps_end) begin
                    o_op    = OP_A_OOM;
                    n_state = S_FIN;
                end else begin
                    o_op    = OP_A_REGROW;
                    n_state = S_A_FOLLOW;
                end
            end
            S_FIN: begin
                if (!i_st.out_busy) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ctx_grow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ctx_grow <= n_ctx_grow;
        end
    end

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DECODE))
        else $error("accepted request did not move to decode");

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !i_st.out_busy) |=> (r_state == S_IDLE))
        else $error("result not handed to the output register");

    a_grow_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_G_GROW) |=> (r_ctx_grow && r_state == S_R_START))
        else $error("grow did not start an insertion walk");

endmodule

`default_nettype wire

// File: design/ffa_dp.sv
// Datapath of the allocator: header store, walk pointers, size arithmetic and
// the result register. Depends on ffa_pkg; controlled by ffa_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ffa_dp import ffa_pkg::*; #(
    parameter int HEAP_UNITS = 4096,
    parameter int UNIT_BYTES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_op               i_op,
    output t_dp_status           o_st,
    input  logic [GROW_W-1:0]    i_min_grow,
    input  logic                 i_command,
    input  logic [BYTES_W-1:0]   i_request_bytes,
    input  logic [PAYLOAD_W-1:0] i_free_unit,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PAYLOAD_W-1:0] o_payload_unit,
    output logic [STATUS_W-1:0]  o_status
);

    localparam int IW    = $clog2(HEAP_UNITS);
    localparam int SW    = IW + 1;
    localparam int XW    = BYTES_W + 1;
    localparam int NW    = XW;
    localparam int RSH   = XW + 7;
    localparam int MW    = RSH;
    localparam int PW    = XW + MW;
    localparam int WW    = ((SW > NW) ? SW : NW) + 1;
    localparam int LIMIT = 4 * HEAP_UNITS + 8;
    localparam int CW    = $clog2(LIMIT + 1);
    localparam longint RECIP_L =
        ((longint'(1) << RSH) + longint'(UNIT_BYTES) - 1) / longint'(UNIT_BYTES);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    logic [IW-1:0] mem_next [HEAP_UNITS];
    logic [SW-1:0] mem_size [HEAP_UNITS];

    logic                 r_cmd;
    logic [BYTES_W-1:0]   r_bytes;
    logic [PAYLOAD_W-1:0] r_unit;
    logic [PW-1:0]        r_prod;
    logic [NW-1:0]        r_need;
    logic [IW-1:0]        r_p;
    logic [IW-1:0]        r_prev;
    logic [IW-1:0]        r_bp;
    logic [IW-1:0]        r_nxt;
    logic [SW-1:0]        r_sb;
    logic [IW-1:0]        r_rover;
    logic [SW-1:0]        r_brk;
    logic [CW-1:0]        r_asteps;
    logic [CW-1:0]        r_rsteps;
    logic [PAYLOAD_W-1:0] r_res_unit;
    logic [STATUS_W-1:0]  r_res_status;
    logic                 r_out_valid;
    logic [PAYLOAD_W-1:0] r_out_unit;
    logic [STATUS_W-1:0]  r_out_status;
    logic [IW-1:0]        r_rd_next_raw;
    logic [SW-1:0]        r_rd_size_raw;
    logic                 r_rd_zn;
    logic                 r_rd_zs;
    logic                 r_v0_next;
    logic                 r_v0_size;

    logic [IW-1:0] rd_next;
    logic [SW-1:0] rd_size;
    logic [IW-1:0] raddr;
    logic          we_next;
    logic          we_size;
    logic [IW-1:0] waddr_next;
    logic [IW-1:0] waddr_size;
    logic [IW-1:0] wdata_next;
    logic [SW-1:0] wdata_size;
    logic [NW-1:0] nu;
    logic [SW-1:0] newsz;
    logic [SW-1:0] merge_sum;
    logic [XW-1:0] x_round;

    // Entry 0 is the sentinel; until written it reads as self-linked, size zero.
    assign rd_next = r_rd_zn ? '0 : r_rd_next_raw;
    assign rd_size = r_rd_zs ? '0 : r_rd_size_raw;

    assign nu        = (r_need < NW'(i_min_grow)) ? NW'(i_min_grow) : r_need;
    assign newsz     = SW'(WW'(rd_size) - WW'(r_need));
    assign merge_sum = SW'(WW'(r_sb) + WW'(rd_size));
    assign x_round   = XW'(r_bytes) + XW'(UNIT_BYTES - 1);

    always_comb begin
        o_st.cmd_free    = (r_cmd == CMD_FREE);
        o_st.free_ok     = (WW'(r_unit) >= WW'(2)) && (WW'(r_unit) < WW'(HEAP_UNITS));
        o_st.a_fit       = (WW'(rd_size) >= WW'(r_need));
        o_st.a_exact     = (WW'(rd_size) == WW'(r_need));
        o_st.a_at_rover  = (r_p == r_rover);
        o_st.a_steps_end = (r_asteps == CW'(LIMIT));
        o_st.g_fail      = (WW'(r_brk) + WW'(nu)) > WW'(HEAP_UNITS);
        o_st.r_found     = ((r_bp > r_p) && (r_bp < rd_next)) ||
                           ((r_p >= rd_next) && ((r_bp > r_p) || (r_bp < rd_next)));
        o_st.r_steps_end = (r_rsteps == CW'(LIMIT));
        o_st.r_merge_b   = (WW'(r_bp) + WW'(rd_size)) == WW'(r_nxt);
        o_st.r_merge_p   = (WW'(r_p) + WW'(rd_size)) == WW'(r_bp);
        o_st.out_busy    = r_out_valid && !i_out_ready;
    end

    // Header store port control.
    always_comb begin
        raddr      = r_p;
        we_next    = 1'b0;
        we_size    = 1'b0;
        waddr_next = r_p;
        waddr_size = r_p;
        wdata_next = rd_next;
        wdata_size = merge_sum;
        case (i_op)
            OP_NEED:      raddr = r_rover;
            OP_A_FOLLOW:  raddr = rd_next;
            OP_A_ADV:     raddr = rd_next;
            OP_A_REGROW:  raddr = r_rover;
            OP_R_ADV:     raddr = rd_next;
            OP_R_FOUND:   raddr = r_bp;
            OP_R_BREAD:   raddr = r_nxt;
            OP_R_PSTORE:  raddr = r_bp;
            OP_A_EXACT: begin
                we_next    = 1'b1;
                waddr_next = r_prev;
            end
            OP_A_SPLIT1: begin
                we_size    = 1'b1;
                wdata_size = newsz;
            end
            OP_A_SPLIT2: begin
                we_size    = 1'b1;
                wdata_size = SW'(r_need);
            end
            OP_G_GROW: begin
                we_size    = 1'b1;
                waddr_size = IW'(r_brk);
                wdata_size = SW'(nu);
            end
            OP_R_BLINK: begin
                we_next    = 1'b1;
                waddr_next = r_bp;
                wdata_next = r_nxt;
            end
            OP_R_BMERGE: begin
                we_next    = 1'b1;
                we_size    = 1'b1;
                waddr_next = r_bp;
                waddr_size = r_bp;
            end
            OP_R_PLINK: begin
                we_next    = 1'b1;
                wdata_next = r_bp;
            end
            OP_R_PMERGE: begin
                we_next = 1'b1;
                we_size = 1'b1;
            end
            default: begin
                raddr = r_p;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_next) begin
            mem_next[waddr_next] <= wdata_next;
        end
        if (we_size) begin
            mem_size[waddr_size] <= wdata_size;
        end
        r_rd_next_raw <= mem_next[raddr];
        r_rd_size_raw <= mem_size[raddr];
        r_rd_zn       <= (raddr == '0) && !r_v0_next;
        r_rd_zs       <= (raddr == '0) && !r_v0_size;
    end

    // Working registers; each operation updates only what it owns.
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_cmd   <= i_command;
                r_bytes <= i_request_bytes;
                r_unit  <= i_free_unit;
            end
            OP_MUL: begin
                r_prod <= PW'(x_round) * PW'(RECIP);
            end
            OP_NEED: begin
                r_need   <= NW'(r_prod >> RSH) + NW'(1);
                r_prev   <= r_rover;
                r_asteps <= '0;
            end
            OP_F_START: begin
                r_bp         <= IW'(WW'(r_unit) - WW'(1));
                r_p          <= r_rover;
                r_rsteps     <= '0;
                r_res_unit   <= '0;
                r_res_status <= ST_FREE;
            end
            OP_A_FOLLOW: begin
                r_p <= rd_next;
            end
            OP_A_EXACT: begin
                r_res_unit   <= PAYLOAD_W'({1'b0, r_p} + SW'(1));
                r_res_status <= ST_ALLOC;
            end
            OP_A_SPLIT1: begin
                r_p <= IW'(WW'(r_p) + WW'(newsz));
            end
            OP_A_SPLIT2: begin
                r_res_unit   <= PAYLOAD_W'({1'b0, r_p} + SW'(1));
                r_res_status <= ST_ALLOC;
            end
            OP_A_ADV: begin
                r_asteps <= r_asteps + CW'(1);
                r_prev   <= r_p;
                r_p      <= rd_next;
            end
            OP_A_OOM: begin
                r_res_unit   <= '0;
                r_res_status <= ST_OOM;
            end
            OP_A_REGROW: begin
                r_asteps <= r_asteps + CW'(1);
                r_prev   <= r_rover;
            end
            OP_G_GROW: begin
                r_bp     <= IW'(r_brk);
                r_p      <= r_rover;
                r_rsteps <= '0;
            end
            OP_R_ADV: begin
                r_rsteps <= r_rsteps + CW'(1);
                r_p      <= rd_next;
            end
            OP_R_FOUND: begin
                r_nxt <= rd_next;
            end
            OP_R_BREAD: begin
                r_sb <= rd_size;
            end
            OP_R_PSTORE: begin
                r_sb <= rd_size;
            end
            default: begin
                r_need <= r_need;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rover     <= '0;
            r_brk       <= SW'(1);
            r_out_valid <= 1'b0;
            r_v0_next   <= 1'b0;
            r_v0_size   <= 1'b0;
        end else begin
            if (we_next && waddr_next == '0) begin
                r_v0_next <= 1'b1;
            end
            if (we_size && waddr_size == '0) begin
                r_v0_size <= 1'b1;
            end
            if (i_op == OP_G_GROW) begin
                r_brk <= SW'(WW'(r_brk) + WW'(nu));
            end
            if (i_op == OP_A_EXACT || i_op == OP_A_SPLIT2) begin
                r_rover <= r_prev;
            end
            if (i_op == OP_R_PLINK || i_op == OP_R_PMERGE) begin
                r_rover <= r_p;
            end
            if (i_op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_OUT) begin
            r_out_unit   <= r_res_unit;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_unit = r_out_unit;
    assign o_status       = r_out_status;

    a_rover_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op != OP_A_EXACT && i_op != OP_A_SPLIT2 && i_op != OP_R_PLINK &&
         i_op != OP_R_PMERGE) |=> $stable(r_rover))
        else $error("rover moved outside an unlink or insertion");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_OUT) |=> r_out_valid)
        else $error("result load did not raise output valid");

    a_brk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_G_GROW) |=> (r_brk <= SW'(HEAP_UNITS) && r_brk > $past(r_brk)))
        else $error("break pointer left the heap");

endmodule

`default_nettype wire

// File: design/first_fit_free_list_allocator.sv
// Top level of the first-fit free-list allocator: APB register, controller and datapath.
// Depends on ffa_pkg, ffa_req_if, ffa_rsp_if, ffa_ctrl and ffa_dp.
`timescale 1ns / 1ps
`default_nettype none

// The allocator manages a heap of HEAP_UNITS header-sized units (HEAP_UNITS
// must be a power of two) through an address-ordered circular free list kept
// in a header store of next links and sizes. An allocate transaction asks for
// request_bytes, which become ceil(bytes / UNIT_BYTES) + 1 units, and gets the
// payload unit of the first free block that fits after the roving pointer,
// status 0; an exact fit is unlinked and a larger block gives up its tail.
// When the walk comes round to the rover, the heap grows at the break by at
// least min_grow_units units and the walk continues; if that growth would
// pass the heap end the transaction answers status 1 with payload 0. A free
// transaction returns its block to the list, merging it with free neighbors,
// and always answers status 2. Units 0 and 1 and units at or past the heap
// end are ignored by free; freeing a unit that was never allocated is not
// checked. One transaction is worked on at a time. The header store has a
// single read port and each visited header is one read, so an allocate
// reads the free-list headers it visits one after another; a split writes
// the shrunk block's size and then the new block's size, and a grow adds a
// free-list insertion. A free walks the list to find its place and merges
// with each free neighbor. Either one also waits while the previous result
// still sits unaccepted in the output register. A new request is accepted
// while the previous result still waits in the output register.
// min_grow_units is written at byte address 0 of the APB port; the user must
// write it only while the block is idle, which the block does not enforce.
module first_fit_free_list_allocator import ffa_pkg::*; #(
    parameter int HEAP_UNITS = 4096,
    parameter int UNIT_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ffa_req_if.sink               i_req,
    ffa_rsp_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [GROW_W-1:0] r_min_grow;
    logic              reg_sel;
    t_dp_op            dp_op;
    t_dp_status        dp_st;
    logic              in_ready;

    // Register index is the word address; only min_grow_units exists.
    assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_MIN_GROW);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? CFG_DATA_W'(r_min_grow) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_grow <= MIN_GROW_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_min_grow <= pwdata[GROW_W-1:0];
        end
    end

    // The controller sequences every request; the datapath owns all storage.
    ffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_st       (dp_st),
        .o_op       (dp_op)
    );

    assign i_req.ready = in_ready;

    ffa_dp #(
        .HEAP_UNITS (HEAP_UNITS),
        .UNIT_BYTES (UNIT_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (dp_op),
        .o_st            (dp_st),
        .i_min_grow      (r_min_grow),
        .i_command       (i_req.command),
        .i_request_bytes (i_req.request_bytes),
        .i_free_unit     (i_req.free_unit),
        .o_out_valid     (o_rsp.valid),
        .i_out_ready     (o_rsp.ready),
        .o_payload_unit  (o_rsp.payload_unit),
        .o_status        (o_rsp.status)
    );

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the first-fit free-list allocator.
// Depends on ffa_pkg, ffa_req_if, ffa_rsp_if and first_fit_free_list_allocator.
`timescale 1ns / 1ps

module tb;
    import ffa_pkg::*;

    localparam int HEAP      = 4096;
    localparam int UNIT_B    = 16;
    localparam int WALK_MAX  = 4 * HEAP + 8;
    localparam int N_RANDOM  = 880;
    localparam int N_PHASES  = 4;
    localparam int DRAIN_CYC = 40;
    localparam longint CYCLE_LIMIT = 3_000_000;

    // How a directed row picks its transaction.
    typedef enum logic [1:0] {K_ALLOC, K_FREE_HELD, K_FREE_RAW} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [BYTES_W-1:0]     bytes;
        logic [PAYLOAD_W-1:0]   unit;
        bit                     typed;
        logic [PAYLOAD_W-1:0]   pay;
        logic [STATUS_W-1:0]    st;
    } t_dir_row;

    typedef struct {
        logic [PAYLOAD_W-1:0] pay;
        logic [STATUS_W-1:0]  st;
    } t_answer;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel, penable, pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    ffa_req_if req_if ();
    ffa_rsp_if rsp_if ();

    first_fit_free_list_allocator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the heap: free-list links and sizes, rover, break and the
    // growth setting. Sizes are 13 bits wide, links 12 bits, so assignments
    // wrap the same way the hardware stores them.
    logic [PAYLOAD_W-1:0] shadow_next [HEAP];
    logic [12:0]          shadow_size [HEAP];
    int unsigned          shadow_rover;
    int unsigned          shadow_break;
    int unsigned          shadow_min_grow;

    t_answer              pending_answers[$];
    logic [PAYLOAD_W-1:0] held_units[$];
    bit                   failed = 1'b0;
    bit                   quiet  = 1'b0;
    longint               cycle_count = 0;

    // Put the block headed at hdr back into the address-ordered list and merge
    // it with free neighbors. Returns 0 when the walk overran its bound.
    function automatic bit shadow_release(int unsigned hdr);
        int unsigned bp, p, nxt, steps;
        bp = hdr % HEAP;
        p = shadow_rover;
        steps = 0;
        while (!(bp > p && bp < shadow_next[p])) begin
            nxt = shadow_next[p];
            if (p >= nxt && (bp > p || bp < nxt)) break;
            p = nxt;
            steps++;
            if (steps > WALK_MAX) return 1'b0;
        end
        nxt = shadow_next[p];
        if (bp + shadow_size[bp] == nxt) begin
            shadow_size[bp] = shadow_size[bp] + shadow_size[nxt];
            shadow_next[bp] = shadow_next[nxt];
        end else begin
            shadow_next[bp] = nxt;
        end
        if (p + shadow_size[p] == bp) begin
            shadow_size[p] = shadow_size[p] + shadow_size[bp];
            shadow_next[p] = shadow_next[bp];
        end else begin
            shadow_next[p] = bp;
        end
        shadow_rover = p;
        return 1'b1;
    endfunction

    // Extend the heap at the break; fails when the heap end would be passed.
    function automatic bit shadow_grow(int unsigned need);
        int unsigned nu;
        nu = (need < shadow_min_grow) ? shadow_min_grow : need;
        if (shadow_break + nu > HEAP) return 1'b0;
        shadow_size[shadow_break % HEAP] = nu;
        void'(shadow_release(shadow_break % HEAP));
        shadow_break = shadow_break + nu;
        return 1'b1;
    endfunction

    // First-fit search after the rover. Returns header index + 1, or 0.
    function automatic int unsigned shadow_allocate(int unsigned nbytes);
        int unsigned need, prev, p, steps;
        need = (nbytes + UNIT_B - 1) / UNIT_B + 1;
        prev = shadow_rover;
        p = shadow_next[prev];
        steps = 0;
        forever begin
            if (shadow_size[p] >= need) begin
                if (shadow_size[p] == need) begin
                    shadow_next[prev] = shadow_next[p];
                end else begin
                    shadow_size[p] = shadow_size[p] - need;
                    p = (p + shadow_size[p]) % HEAP;
                    shadow_size[p] = need;
                end
                shadow_rover = prev;
                return p + 1;
            end
            if (p == shadow_rover) begin
                if (!shadow_grow(need)) return 0;
                p = shadow_rover;
            end
            steps++;
            if (steps > WALK_MAX) return 0;
            prev = p;
            p = shadow_next[p];
        end
    endfunction

    // Applies one accepted transaction to the shadow heap and returns the
    // answer the block must give for it.
    function automatic t_answer heap_step(logic cmd, logic [BYTES_W-1:0] bytes,
                                          logic [PAYLOAD_W-1:0] unit);
        t_answer     a;
        int unsigned got;
        if (cmd == CMD_ALLOC) begin
            got = shadow_allocate(bytes);
            a.pay = got[PAYLOAD_W-1:0];
            a.st  = (got != 0) ? ST_ALLOC : ST_OOM;
        end else begin
            if (unit >= 2) void'(shadow_release(unit - 1));
            a.pay = '0;
            a.st  = ST_FREE;
        end
        return a;
    endfunction

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(99) < 19);
    endfunction

    // Presents one request and waits for its handshake. The prediction is
    // made at acceptance so expectations line up in transaction order. A
    // typed row overrides the predicted answer, but the shadow still updates.
    task automatic send_request(logic cmd, logic [BYTES_W-1:0] bytes,
                                logic [PAYLOAD_W-1:0] unit, bit typed, t_answer typed_ans);
        t_answer a;
        while (idle_roll()) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.command       <= cmd;
        req_if.request_bytes <= bytes;
        req_if.free_unit     <= unit;
        do @(posedge i_clk); while (!req_if.ready);
        a = heap_step(cmd, bytes, unit);
        if (cmd == CMD_ALLOC && a.st == ST_ALLOC && a.pay >= 2) held_units.push_back(a.pay);
        pending_answers.push_back(typed ? typed_ans : a);
    endtask

    // Register writes happen only with the block idle: every answer back,
    // then a further drain wait for the output register to settle.
    task automatic write_min_grow(logic [GROW_W-1:0] value);
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(REG_MIN_GROW));
        pwdata  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_min_grow = value;
    endtask

    // Result side: compare each accepted transaction with the oldest
    // expectation, then pick the stall for the next cycle.
    task automatic check_answer();
        t_answer e;
        if (pending_answers.size() == 0) begin
            $error("result with no expectation: payload_unit=%0d status=%0d",
                   rsp_if.payload_unit, rsp_if.status);
            failed = 1'b1;
        end else begin
            e = pending_answers.pop_front();
            if (rsp_if.payload_unit !== e.pay) begin
                $error("payload_unit expected %0d actual %0d", e.pay, rsp_if.payload_unit);
                failed = 1'b1;
            end
            if (rsp_if.status !== e.st) begin
                $error("status expected %0d actual %0d", e.st, rsp_if.status);
                failed = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) check_answer();
            rsp_if.ready <= !idle_roll();
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    t_dir_row dir_rows[20];

    initial begin
        t_answer              none;
        t_answer              typed_ans;
        int                   r, idx, sent;
        logic [BYTES_W-1:0]   nbytes;
        logic [PAYLOAD_W-1:0] unit;
        logic [GROW_W-1:0]    phase_grow [N_PHASES];

        // Directed rows: tiny sizes and the one-unit case, byte counts that
        // straddle a unit boundary, requests too large for the heap, frees
        // of the sentinel units, and frees that exercise merging.
        dir_rows = '{
            '{K_ALLOC,     16'd0,     12'd0, 1'b0, 12'd0, ST_ALLOC},
            '{K_ALLOC,     16'd1,     12'd0, 1'b0, 12'd0, ST_ALLOC},
            '{K_ALLOC,     16'd16,    12'd0, 1'b0, 12'd0, ST_ALLOC},
            '{K_ALLOC,     16'd17,    12'd0, 1'b0, 12'd0, ST_ALLOC},
            '{K_ALLOC,     16'hFFFF,  12'd0, 1'b1, 12'd0, ST_OOM},
            '{K_ALLOC,     16'd65520, 12'd0, 1'b1, 12'd0, ST_OOM},
            '{K_FREE_RAW,  16'd0,     12'd0, 1'b1, 12'd0, ST_FREE},
            '{K_FREE_RAW,  16'hFFFF,  12'd1, 1'b1, 12'd0, ST_FREE},
            '{K_FREE_HELD, 16'd0,     12'd0, 1'b1, 12'd0, ST_FREE},
            '{K_ALLOC,     16'd100,   12'd0, 1'b0, 12'd0, ST_ALLOC},
            '{K_ALLOC,     16'd4000,  12'd0, 1'b0, 12'd0, ST_ALLOC},
            '{K_FREE_HELD, 16'd0,     12'd0, 1'b1, 12'd0, ST_FREE},
            '{K_FREE_HELD, 16'd0,     12'd0, 1'b1, 12'd0, ST_FREE},
            '{K_FREE_HELD, 16'd0,     12'd0, 1'b1, 12'd0, ST_FREE},
            '{K_ALLOC,     16'd0,     12'd0, 1'b0, 12'd0, ST_ALLOC},
            '{K_ALLOC,     16'd32,    12'd0, 1'b0, 12'd0, ST_ALLOC},
            '{K_FREE_HELD, 16'd0,     12'd0, 1'b1, 12'd0, ST_FREE},
            '{K_ALLOC,     16'd1000,  12'd0, 1'b0, 12'd0, ST_ALLOC},
            '{K_FREE_HELD, 16'd0,     12'd0, 1'b1, 12'd0, ST_FREE},
            '{K_FREE_HELD, 16'd0,     12'd0, 1'b1, 12'd0, ST_FREE}
        };
        phase_grow[0] = MIN_GROW_RESET;
        phase_grow[1] = 12'd4095;
        phase_grow[2] = 12'd16;
        phase_grow[3] = GROW_W'($urandom_range(1, 4095));
        none = '{pay: '0, st: '0};

        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req_if.valid         = 1'b0;
        req_if.command       = CMD_ALLOC;
        req_if.request_bytes = '0;
        req_if.free_unit     = '0;
        rsp_if.ready         = 1'b0;
        foreach (shadow_next[k]) begin
            shadow_next[k] = '0;
            shadow_size[k] = '0;
        end
        shadow_rover    = 0;
        shadow_break    = 1;
        shadow_min_grow = MIN_GROW_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The smallest growth setting keeps the directed part easy to follow.
        write_min_grow(12'd1);
        foreach (dir_rows[i]) begin
            typed_ans = '{pay: dir_rows[i].pay, st: dir_rows[i].st};
            case (dir_rows[i].kind)
                K_ALLOC: begin
                    send_request(CMD_ALLOC, dir_rows[i].bytes, '0, dir_rows[i].typed, typed_ans);
                end
                K_FREE_RAW: begin
                    send_request(CMD_FREE, dir_rows[i].bytes, dir_rows[i].unit,
                                 dir_rows[i].typed, typed_ans);
                end
                default: begin
                    if (held_units.size() != 0)
                        send_request(CMD_FREE, '0, held_units.pop_back(),
                                     dir_rows[i].typed, typed_ans);
                end
            endcase
        end

        // Random part, split into phases with a different growth setting each.
        // Mostly small requests so the heap churns through splits and merges;
        // a few medium and full-range requests push it into out-of-memory.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_min_grow(phase_grow[ph]);
            sent = 0;
            while (sent < N_RANDOM / N_PHASES) begin
                quiet = (ph == 2) && (sent >= 40) && (sent < 160);
                r = $urandom_range(99);
                if (r < 92 && r >= 50 && held_units.size() != 0) begin
                    idx = $urandom_range(held_units.size() - 1);
                    unit = held_units[idx];
                    held_units.delete(idx);
                    send_request(CMD_FREE, BYTES_W'($urandom), unit, 1'b0, none);
                    sent++;
                end else if (r >= 92) begin
                    // Sentinel frees are ignored by the block and not counted.
                    send_request(CMD_FREE, BYTES_W'($urandom), PAYLOAD_W'($urandom_range(1)),
                                 1'b0, none);
                end else begin
                    r = $urandom_range(99);
                    if (r < 85) nbytes = BYTES_W'($urandom_range(255));
                    else if (r < 97) nbytes = BYTES_W'($urandom_range(2047));
                    else nbytes = BYTES_W'($urandom);
                    send_request(CMD_ALLOC, nbytes, PAYLOAD_W'($urandom), 1'b0, none);
                    sent++;
                end
            end
            quiet = 1'b0;
        end

        req_if.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (!failed) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
